### sv/bsph_pkg.sv
`timescale 1ns / 1ps
package bsph_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Z = 2'd2;
    localparam logic signed [CFG_DATA_W-1:0] SCALE_RESET = 32'sd65536;

    // Queue between the front and back parts
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    localparam int NUM_EXTREMES = 6;
    localparam int RADIUS_W = 33;

    typedef struct packed {
        logic signed [31:0] vertex_x;
        logic signed [31:0] vertex_y;
        logic signed [31:0] vertex_z;
        logic               last_vertex;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0]         center_x;
        logic signed [31:0]         center_y;
        logic signed [31:0]         center_z;
        logic [RADIUS_W-1:0]        sphere_radius;
    } result_t;

    typedef struct packed {
        logic               empty;
        logic [Q_CNT_W-1:0] count;
    } q_status_t;

endpackage

### sv/bsph_fifo.sv
`timescale 1ns / 1ps
module bsph_fifo #(
    parameter int WIDTH = 97
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [WIDTH-1:0]      wr_data,
    input  logic                  rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output bsph_pkg::q_status_t   status
);
    import bsph_pkg::*;

    logic [WIDTH-1:0]   mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + Q_CNT_W'(wr_en) - Q_CNT_W'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data      = mem_reg[rd_ptr_reg];
    assign status.empty = (count_reg == '0);
    assign status.count = count_reg;

endmodule

### sv/bsph_front.sv
`timescale 1ns / 1ps
module bsph_front #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  bsph_pkg::in_item_t                item,
    output logic                              full,
    input  logic                              cfg_wr_en,
    input  logic [bsph_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bsph_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  bsph_pkg::q_status_t               q_status,
    output logic                              q_push,
    output logic [3*COORD_WIDTH:0]            q_data
);
    import bsph_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (CW - 1)) - 64'sd1;
    localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

    logic signed [31:0] scale_reg [3];
    logic signed [63:0] prod_reg [3];
    logic signed [63:0] prod_next [3];
    logic               last_reg;
    logic               valid_reg, valid_next;
    logic signed [63:0] shifted [3];
    logic [CW-1:0]      sat [3];
    logic               accept;

    assign full   = ({1'b0, q_status.count} + (Q_CNT_W+1)'(valid_reg)) >= (Q_CNT_W+1)'(Q_DEPTH);
    assign accept = push && !full;

    always_comb
    begin
        prod_next[0] = item.vertex_x * scale_reg[0];
        prod_next[1] = item.vertex_y * scale_reg[1];
        prod_next[2] = item.vertex_z * scale_reg[2];
        valid_next   = accept;
        for (int a = 0; a < 3; a++)
        begin
            // floor of the Q32.32 product back to Q16.16, then clamp
            shifted[a] = prod_reg[a] >>> 16;
            if (shifted[a] > SAT_HI)
                sat[a] = SAT_HI[CW-1:0];
            else if (shifted[a] < SAT_LO)
                sat[a] = SAT_LO[CW-1:0];
            else
                sat[a] = shifted[a][CW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            for (int a = 0; a < 3; a++)
                scale_reg[a] <= SCALE_RESET;
        end
        else
        begin
            valid_reg <= valid_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_SCALE_X: scale_reg[0] <= cfg_data;
                    REG_SCALE_Y: scale_reg[1] <= cfg_data;
                    REG_SCALE_Z: scale_reg[2] <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prod_reg <= prod_next;
            last_reg <= item.last_vertex;
        end
    end

    assign q_push = valid_reg;
    assign q_data = {last_reg, sat[2], sat[1], sat[0]};

endmodule

### sv/bsph_back.sv
`timescale 1ns / 1ps
module bsph_back #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  bsph_pkg::q_status_t      q_status,
    input  logic [3*COORD_WIDTH:0]   q_data,
    output logic                     q_pop,
    output bsph_pkg::result_t        result,
    output logic                     empty,
    input  logic                     pop
);
    import bsph_pkg::*;

    localparam int CW  = COORD_WIDTH;
    localparam int H   = (CW + 1) / 2;
    localparam int DH  = CW - H;
    localparam int SW  = 2 * CW + 2;
    localparam int N   = CW + 1;
    localparam int RW  = N + 3;
    localparam int ITW = $clog2(N + 1);

    localparam logic [2:0] S_TRACK  = 3'd0;
    localparam logic [2:0] S_CENTER = 3'd1;
    localparam logic [2:0] S_DIFF   = 3'd2;
    localparam logic [2:0] S_MAC    = 3'd3;
    localparam logic [2:0] S_CMP    = 3'd4;
    localparam logic [2:0] S_SQRT   = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0]           state_reg, state_next;
    logic                 first_reg, first_next;
    logic signed [CW-1:0] min_reg [3], min_next [3];
    logic signed [CW-1:0] max_reg [3], max_next [3];
    logic signed [CW-1:0] ext_reg [NUM_EXTREMES][3], ext_next [NUM_EXTREMES][3];
    logic signed [CW-1:0] c_reg [3], c_next [3];
    logic [2:0]           k_reg, k_next;
    logic [1:0]           a_reg, a_next;
    logic [1:0]           ph_reg, ph_next;
    logic [CW-1:0]        d_reg, d_next;
    logic [SW-1:0]        acc_reg, acc_next;
    logic [SW-1:0]        best_reg, best_next;
    logic [SW-1:0]        n_reg, n_next;
    logic [RW-1:0]        rem_reg, rem_next;
    logic [N-1:0]         root_reg, root_next;
    logic [ITW-1:0]       it_reg, it_next;
    result_t              res_reg, res_next;
    logic                 res_valid_reg, res_valid_next;

    logic signed [CW-1:0] p [3];
    logic                 p_last;
    logic signed [CW:0]   sum_c, diff;
    logic [SW-1:0]        term, best_new;
    logic [RW-1:0]        rem_sh, trial;
    logic signed [63:0]   c64;
    logic [63:0]          root64;

    assign p[0]   = q_data[CW-1:0];
    assign p[1]   = q_data[2*CW-1:CW];
    assign p[2]   = q_data[3*CW-1:2*CW];
    assign p_last = q_data[3*CW];
    assign q_pop  = (state_reg == S_TRACK) && !q_status.empty;

    always_comb
    begin
        state_next     = state_reg;
        first_next     = first_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        ext_next       = ext_reg;
        c_next         = c_reg;
        k_next         = k_reg;
        a_next         = a_reg;
        ph_next        = ph_reg;
        d_next         = d_reg;
        acc_next       = acc_reg;
        best_next      = best_reg;
        n_next         = n_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        it_next        = it_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !pop;
        sum_c          = '0;
        diff           = (CW+1)'(ext_reg[k_reg][a_reg]) - (CW+1)'(c_reg[a_reg]);
        term           = '0;
        best_new       = (acc_reg > best_reg) ? acc_reg : best_reg;
        rem_sh         = {rem_reg[RW-3:0], n_reg[SW-1:SW-2]};
        trial          = RW'({root_reg, 2'b01});
        c64            = '0;
        root64         = 64'(root_reg);

        case (state_reg)
            S_TRACK:
            begin
                if (q_pop)
                begin
                    if (first_reg)
                    begin
                        min_next = p;
                        max_next = p;
                        for (int k = 0; k < NUM_EXTREMES; k++)
                            ext_next[k] = p;
                    end
                    else
                    begin
                        for (int a = 0; a < 3; a++)
                        begin
                            if (p[a] < min_reg[a])
                            begin
                                min_next[a]   = p[a];
                                ext_next[2*a] = p;
                            end
                            else if (p[a] > max_reg[a])
                            begin
                                max_next[a]     = p[a];
                                ext_next[2*a+1] = p;
                            end
                        end
                    end
                    first_next = p_last;
                    if (p_last)
                        state_next = S_CENTER;
                end
            end
            S_CENTER:
            begin
                for (int a = 0; a < 3; a++)
                begin
                    // half sum, truncated toward zero
                    sum_c     = (CW+1)'(min_reg[a]) + (CW+1)'(max_reg[a]);
                    sum_c     = sum_c + (CW+1)'(sum_c[CW]);
                    sum_c     = sum_c >>> 1;
                    c_next[a] = sum_c[CW-1:0];
                end
                k_next     = '0;
                a_next     = '0;
                acc_next   = '0;
                best_next  = '0;
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                d_next     = diff[CW] ? CW'(-diff) : diff[CW-1:0];
                ph_next    = '0;
                state_next = S_MAC;
            end
            S_MAC:
            begin
                // square of d from three partial products
                case (ph_reg)
                    2'd0: term = SW'(d_reg[H-1:0] * d_reg[H-1:0]);
                    2'd1: term = SW'(d_reg[CW-1:H] * d_reg[H-1:0]) << (H + 1);
                    default: term = SW'(d_reg[CW-1:H] * d_reg[CW-1:H]) << (2 * H);
                endcase
                acc_next = acc_reg + term;
                ph_next  = ph_reg + 2'd1;
                if (ph_reg == 2'd2)
                begin
                    if (a_reg == 2'd2)
                        state_next = S_CMP;
                    else
                    begin
                        a_next     = a_reg + 2'd1;
                        state_next = S_DIFF;
                    end
                end
            end
            S_CMP:
            begin
                best_next = best_new;
                acc_next  = '0;
                a_next    = '0;
                if (k_reg == 3'(NUM_EXTREMES - 1))
                begin
                    n_next     = best_new;
                    rem_next   = '0;
                    root_next  = '0;
                    it_next    = '0;
                    state_next = S_SQRT;
                end
                else
                begin
                    k_next     = k_reg + 3'd1;
                    state_next = S_DIFF;
                end
            end
            S_SQRT:
            begin
                n_next = n_reg << 2;
                if (rem_sh >= trial)
                begin
                    rem_next  = rem_sh - trial;
                    root_next = {root_reg[N-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh;
                    root_next = {root_reg[N-2:0], 1'b0};
                end
                it_next = it_reg + 1'b1;
                if (it_reg == ITW'(N - 1))
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!res_valid_reg)
                begin
                    for (int a = 0; a < 3; a++)
                    begin
                        c64 = 64'(c_reg[a]);
                        if (c64 > 64'sd2147483647)
                            c64 = 64'sd2147483647;
                        else if (c64 < -64'sd2147483648)
                            c64 = -64'sd2147483648;
                        case (a)
                            0: res_next.center_x = c64[31:0];
                            1: res_next.center_y = c64[31:0];
                            default: res_next.center_z = c64[31:0];
                        endcase
                    end
                    res_next.sphere_radius = (root64 > 64'h1_FFFF_FFFF) ?
                        {RADIUS_W{1'b1}} : root64[RADIUS_W-1:0];
                    res_valid_next = 1'b1;
                    state_next     = S_TRACK;
                end
            end
            default: state_next = S_TRACK;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_TRACK;
            first_reg     <= 1'b1;
            res_valid_reg <= 1'b0;
            k_reg         <= '0;
            a_reg         <= '0;
            ph_reg        <= '0;
            it_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            first_reg     <= first_next;
            res_valid_reg <= res_valid_next;
            k_reg         <= k_next;
            a_reg         <= a_next;
            ph_reg        <= ph_next;
            it_reg        <= it_next;
        end
    end

    always_ff @(posedge clk)
    begin
        min_reg  <= min_next;
        max_reg  <= max_next;
        ext_reg  <= ext_next;
        c_reg    <= c_next;
        d_reg    <= d_next;
        acc_reg  <= acc_next;
        best_reg <= best_next;
        n_reg    <= n_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        res_reg  <= res_next;
    end

    assign result = res_reg;
    assign empty  = !res_valid_reg;

endmodule

### sv/bounding_sphere_from_vertices.sv
`timescale 1ns / 1ps
// Bounding sphere of a streamed mesh. Push vertices (signed Q16.16) one per
// request; each is scaled per axis by the scale registers (floor of the
// product, clamped to COORD_WIDTH bits) and folded into the running box and
// its six extreme points. The vertex flagged last_vertex yields one result:
// the box centre (half sum, truncated toward zero) and the radius, the floor
// square root of the largest squared distance from the centre to an extreme
// point (unsigned Q17.16, clamped). Vertices are taken one per cycle while a
// mesh streams; the front multiplier stage feeds a four-entry queue, so full
// rises only when the back end stalls. After the last vertex the back end
// works out the distance sums, built from half-width partial products taken
// in turn, and the bit-serial square root; the next mesh waits in the
// queue meanwhile. Write the scale registers only while the block is idle.
module bounding_sphere_from_vertices #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    input  bsph_pkg::in_item_t               item,
    output logic                             full,
    output bsph_pkg::result_t                result,
    output logic                             empty,
    input  logic                             pop,
    input  logic                             cfg_wr_en,
    input  logic [bsph_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bsph_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bsph_pkg::*;

    localparam int QW = 3 * COORD_WIDTH + 1;

    q_status_t       q_status;
    logic            q_push;
    logic            q_pop;
    logic [QW-1:0]   q_wr_data;
    logic [QW-1:0]   q_rd_data;

    // scale and clamp each request
    bsph_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_status  (q_status),
        .q_push    (q_push),
        .q_data    (q_wr_data)
    );

    // hold scaled vertices while the back end is busy
    bsph_fifo #(.WIDTH(QW)) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_data),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .status  (q_status)
    );

    // track the box, then compute centre and radius
    bsph_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .q_data   (q_rd_data),
        .q_pop    (q_pop),
        .result   (result),
        .empty    (empty),
        .pop      (pop)
    );

endmodule
